[src/ntl_pkg.sv]
// shared constants, types and resistance table for the ntc thermistor linearizer
`timescale 1ns / 1ps
`default_nettype none
package ntl_pkg;

  // field widths
  localparam int MV_W      = 12;
  localparam int SERIES_W  = 16;
  localparam int TEMP_W    = 15;
  localparam int STATUS_W  = 2;
  localparam int FRAC_BITS = 8;

  // resistance table
  localparam int TABLE_ENTRIES = 136;
  localparam int IDX_W         = 8;
  localparam int ROM_W         = 17;
  localparam int ROMF_W        = ROM_W + FRAC_BITS;

  // arithmetic widths
  localparam int PROD_W   = SERIES_W + MV_W;
  localparam int NUM_W    = PROD_W + FRAC_BITS;
  localparam int RFIX_W   = NUM_W + 1;
  localparam int DIFF_W   = 13;
  localparam int DEN_W    = DIFF_W + FRAC_BITS;
  localparam int FRAC_Q_W = 7;
  localparam int FNUM_W   = DEN_W + FRAC_Q_W;
  localparam int CNT_W    = 6;

  // reset value of the series resistor register
  localparam logic [SERIES_W-1:0] SERIES_RESET = 16'd8250;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COLD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HOT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd3;

  // clamp temperatures in hundredths plus offset
  localparam logic [TEMP_W-1:0] TEMP_COLD = 15'h744D; // -2995
  localparam logic [TEMP_W-1:0] TEMP_HOT  = 15'd10505;
  localparam logic [TEMP_W-1:0] CENTI_PER_DEG = 15'd100;
  localparam logic [FRAC_Q_W-1:0] FRAC_SCALE = 7'd100;

  // thermistor resistance in ohms, one entry per degree from -30 upwards
  localparam logic [ROM_W-1:0] RES_ROM [TABLE_ENTRIES] = '{
    17'd113347, 17'd107565, 17'd102116, 17'd96978, 17'd92132, 17'd87559, 17'd83242,
    17'd79166, 17'd75316, 17'd71677, 17'd68237, 17'd64991, 17'd61919, 17'd59011,
    17'd56258, 17'd53650, 17'd51178, 17'd48835, 17'd46613, 17'd44506, 17'd42506,
    17'd40600, 17'd38791, 17'd37073, 17'd35442, 17'd33892, 17'd32420, 17'd31020,
    17'd29689, 17'd28423, 17'd27219, 17'd26076, 17'd24988, 17'd23951, 17'd22963,
    17'd22021, 17'd21123, 17'd20267, 17'd19450, 17'd18670, 17'd17926, 17'd17214,
    17'd16534, 17'd15886, 17'd15266, 17'd14674, 17'd14108, 17'd13566, 17'd13049,
    17'd12554, 17'd12081, 17'd11628, 17'd11195, 17'd10780, 17'd10382, 17'd10000,
    17'd9634, 17'd9284, 17'd8947, 17'd8624, 17'd8315, 17'd8018, 17'd7734,
    17'd7461, 17'd7199, 17'd6948, 17'd6707, 17'd6475, 17'd6253, 17'd6039,
    17'd5834, 17'd5636, 17'd5445, 17'd5262, 17'd5086, 17'd4917, 17'd4754,
    17'd4597, 17'd4446, 17'd4301, 17'd4161, 17'd4026, 17'd3896, 17'd3771,
    17'd3651, 17'd3535, 17'd3423, 17'd3315, 17'd3211, 17'd3111, 17'd3014,
    17'd2922, 17'd2834, 17'd2748, 17'd2666, 17'd2586, 17'd2509, 17'd2435,
    17'd2364, 17'd2294, 17'd2228, 17'd2163, 17'd2100, 17'd2040, 17'd1981,
    17'd1925, 17'd1870, 17'd1817, 17'd1766, 17'd1716, 17'd1669, 17'd1622,
    17'd1578, 17'd1535, 17'd1493, 17'd1452, 17'd1413, 17'd1375, 17'd1338,
    17'd1303, 17'd1268, 17'd1234, 17'd1202, 17'd1170, 17'd1139, 17'd1110,
    17'd1081, 17'd1053, 17'd1026, 17'd999, 17'd974, 17'd949, 17'd925,
    17'd902, 17'd880, 17'd858
  };

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic srch_init;
    logic srch_step;
    logic frac_prep;
    logic frac_load;
    logic finish;
  } ntl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sense_zero;
    logic srch_done;
    logic edge_idx;
  } ntl_stat_t;

endpackage
`default_nettype wire

[src/ntc_thermistor_linearizer_top.sv]
// top level of the ntc thermistor linearizer
`timescale 1ns / 1ps
`default_nettype none
// Converts a divider reading (rail_mv, sense_mv) into a temperature in
// hundredths of a degree plus 5, with a status code.
// Input: a transaction is taken at a rising edge with start high and busy
// low; rail_mv and sense_mv are sampled at that edge only.
// Output: done is high for exactly one cycle with temp_centi and status
// valid in that cycle; the receiver cannot hold results off.
// Configuration: cfg_we writes cfg_wdata into the series resistor
// register; write only while busy is low and no result is pending.
// The resistance division and the fraction division share one bit-serial
// divider, and the fraction division is skipped when the resistance is
// clamped; the table search is a binary search of 7 or 8 probes. A zero
// sense voltage skips division and search and goes straight to done.
// One transaction at a time; start is taken again in the cycle done rises.
// Reset: synchronous, clears the controller and loads the series
// resistor with 8250 ohms.
module ntc_thermistor_linearizer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ntl_pkg::MV_W-1:0]          rail_mv,
  input  logic [ntl_pkg::MV_W-1:0]          sense_mv,
  input  logic                              cfg_we,
  input  logic [ntl_pkg::SERIES_W-1:0]      cfg_wdata,
  output logic                              done,
  output logic signed [ntl_pkg::TEMP_W-1:0] temp_centi,
  output logic [ntl_pkg::STATUS_W-1:0]      status
);
  import ntl_pkg::*;

  ntl_cmd_t  cmd;
  ntl_stat_t stat;

  // sequencing
  ntl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // arithmetic and result registers
  ntl_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rail_mv    (rail_mv),
    .sense_mv   (sense_mv),
    .temp_centi (temp_centi),
    .status     (status),
    .done       (done)
  );

endmodule
`default_nettype wire

[src/ntl_div.sv]
// shared restoring divider, one quotient bit per cycle while step is high
`timescale 1ns / 1ps
`default_nettype none
module ntl_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [ntl_pkg::DEN_W-1:0]   rem_init,
  input  logic [ntl_pkg::NUM_W-1:0]   nq_init,
  input  logic [ntl_pkg::DEN_W-1:0]   den,
  output logic [ntl_pkg::NUM_W-1:0]   quot
);
  import ntl_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, nq[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  // numerator shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= rem_init;
      nq    <= nq_init;
      den_r <= den;
    end else if (step) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq  <= {nq[NUM_W-2:0], ge};
    end
  end

  assign quot = nq;

endmodule
`default_nettype wire

[src/ntl_datapath.sv]
// datapath: resistance quotient, table search, interpolation and result registers
`timescale 1ns / 1ps
`default_nettype none
module ntl_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ntl_pkg::ntl_cmd_t                 cmd,
  output ntl_pkg::ntl_stat_t                stat,
  input  logic                              cfg_we,
  input  logic [ntl_pkg::SERIES_W-1:0]      cfg_wdata,
  input  logic [ntl_pkg::MV_W-1:0]          rail_mv,
  input  logic [ntl_pkg::MV_W-1:0]          sense_mv,
  output logic signed [ntl_pkg::TEMP_W-1:0] temp_centi,
  output logic [ntl_pkg::STATUS_W-1:0]      status,
  output logic                              done
);
  import ntl_pkg::*;

  logic [SERIES_W-1:0]      series;
  logic [PROD_W-1:0]        prod;
  logic [MV_W-1:0]          sense_r;
  logic signed [RFIX_W-1:0] r_fix;
  logic [IDX_W-1:0]         lo;
  logic [IDX_W-1:0]         hi;
  logic [DEN_W-1:0]         hir;
  logic [DEN_W-1:0]         dif;

  logic                     div_load;
  logic [DEN_W-1:0]         div_rem_init;
  logic [NUM_W-1:0]         div_nq_init;
  logic [DEN_W-1:0]         div_den;
  logic [NUM_W-1:0]         quot;

  logic [IDX_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic                     r_ge_mid;
  logic [IDX_W-1:0]         lo_m1;
  logic [ROM_W-1:0]         rom_hi;
  logic [ROM_W-1:0]         rom_lo;
  logic [ROM_W-1:0]         rom_span;
  logic [ROMF_W-1:0]        hir_full;
  logic [FNUM_W-1:0]        fnum;
  logic                     r_eq_first;
  logic [TEMP_W-1:0]        scaled;
  logic [TEMP_W-1:0]        temp_ok;

  // series resistor register
  always_ff @(posedge clk) begin
    if (rst) begin
      series <= SERIES_RESET;
    end else if (cfg_we) begin
      series <= cfg_wdata;
    end
  end

  // capture the transaction and form series * rail
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod    <= PROD_W'(series * rail_mv);
      sense_r <= sense_mv;
    end
  end

  // divider operand selection: main quotient or interpolation fraction
  always_comb begin
    fnum     = FNUM_W'(hir * FRAC_SCALE);
    div_load = cmd.div_init | cmd.frac_load;
    if (cmd.frac_load) begin
      div_rem_init = fnum[FNUM_W-1:FRAC_Q_W];
      div_nq_init  = {fnum[FRAC_Q_W-1:0], {(NUM_W-FRAC_Q_W){1'b0}}};
      div_den      = dif;
    end else begin
      div_rem_init = '0;
      div_nq_init  = {prod, {FRAC_BITS{1'b0}}};
      div_den      = {{(DEN_W-MV_W){1'b0}}, sense_r};
    end
  end

  ntl_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.div_step),
    .rem_init (div_rem_init),
    .nq_init  (div_nq_init),
    .den      (div_den),
    .quot     (quot)
  );

  // binary search probe and table reads for interpolation
  always_comb begin
    mid_sum    = {1'b0, lo} + {1'b0, hi};
    mid        = mid_sum[IDX_W:1];
    r_ge_mid   = r_fix >= $signed({{(RFIX_W-ROMF_W){1'b0}}, RES_ROM[mid],
                                   {FRAC_BITS{1'b0}}});
    lo_m1      = lo - IDX_W'(1);
    rom_hi     = RES_ROM[lo_m1];
    rom_lo     = RES_ROM[lo];
    rom_span   = rom_hi - rom_lo;
    hir_full   = {rom_hi, {FRAC_BITS{1'b0}}} - r_fix[ROMF_W-1:0];
    r_eq_first = r_fix == $signed({{(RFIX_W-ROMF_W){1'b0}}, RES_ROM[0],
                                   {FRAC_BITS{1'b0}}});
    scaled     = TEMP_W'({{(TEMP_W-IDX_W){1'b0}}, lo_m1} * CENTI_PER_DEG);
    temp_ok    = TEMP_COLD + scaled + {{(TEMP_W-FRAC_Q_W){1'b0}}, quot[FRAC_Q_W-1:0]};
  end

  // resistance, search bounds and interpolation operands
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      r_fix <= $signed({1'b0, quot})
             - $signed({{(RFIX_W-SERIES_W-FRAC_BITS){1'b0}}, series, {FRAC_BITS{1'b0}}});
      lo    <= '0;
      hi    <= IDX_W'(TABLE_ENTRIES);
    end else if (cmd.srch_step) begin
      if (r_ge_mid) begin
        hi <= mid;
      end else begin
        lo <= mid + IDX_W'(1);
      end
    end
    if (cmd.frac_prep) begin
      hir <= hir_full[DEN_W-1:0];
      dif <= {rom_span[DIFF_W-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // status back to the controller
  always_comb begin
    stat.sense_zero = sense_r == '0;
    stat.srch_done  = lo == hi;
    stat.edge_idx   = (lo == '0) || (lo == IDX_W'(TABLE_ENTRIES));
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sense_r == '0) begin
        temp_centi <= '0;
        status     <= ST_ZERO;
      end else if (lo == '0) begin
        temp_centi <= $signed(TEMP_COLD);
        status     <= r_eq_first ? ST_OK : ST_COLD;
      end else if (lo == IDX_W'(TABLE_ENTRIES)) begin
        temp_centi <= $signed(TEMP_HOT);
        status     <= ST_HOT;
      end else begin
        temp_centi <= $signed(temp_ok);
        status     <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

[src/ntl_ctrl.sv]
// controller: sequences divide, search and interpolation for one transaction
`timescale 1ns / 1ps
`default_nettype none
module ntl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output ntl_pkg::ntl_cmd_t  cmd,
  input  ntl_pkg::ntl_stat_t stat
);
  import ntl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_DIVM  = 3'd2;
  localparam logic [2:0] S_RFIX  = 3'd3;
  localparam logic [2:0] S_SRCH  = 3'd4;
  localparam logic [2:0] S_FPREP = 3'd5;
  localparam logic [2:0] S_DIVF  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign busy = state != S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.sense_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = CNT_W'(NUM_W - 1);
          state_next   = S_DIVM;
        end
      end
      S_DIVM: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - CNT_W'(1);
        if (cnt == '0) begin
          state_next = S_RFIX;
        end
      end
      S_RFIX: begin
        cmd.srch_init = 1'b1;
        state_next    = S_SRCH;
      end
      S_SRCH: begin
        if (!stat.srch_done) begin
          cmd.srch_step = 1'b1;
        end else if (stat.edge_idx) begin
          state_next = S_DONE;
        end else begin
          cmd.frac_prep = 1'b1;
          state_next    = S_FPREP;
        end
      end
      S_FPREP: begin
        cmd.frac_load = 1'b1;
        cnt_next      = CNT_W'(FRAC_Q_W - 1);
        state_next    = S_DIVF;
      end
      S_DIVF: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - CNT_W'(1);
        if (cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire
